### rtl/dfr_pkg.sv
package dfr_pkg;

   localparam int MAX_STATES  = 256;
   localparam int MAX_SYMBOLS = 64;
   localparam int STATE_W     = 8;
   localparam int SYM_W       = 6;
   localparam int TBL_AW      = STATE_W + SYM_W;
   localparam int TBL_DEPTH   = MAX_STATES * MAX_SYMBOLS;
   localparam int ENTRY_W     = STATE_W + 1;
   localparam int FREQ_W      = 9;
   localparam int WGT_W       = 15;
   localparam int LIST_W      = 7;
   localparam int NUM_W       = 9;
   localparam int SCNT_W      = 9;
   localparam int MCNT_W      = 7;
   localparam int STACK_DEPTH_DEF = 16384;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_STATE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_STATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [STATE_W-1:0]   src_state;
      logic [SYM_W-1:0]     symbol;
      logic [STATE_W-1:0]   dest_state;
      logic                 dest_present;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0]   new_number;
      logic                 is_numbered;
      logic [NUM_W-1:0]     numbered_total;
      logic                 stack_overflow;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_TCLR,
      ST_IDLE,
      ST_FCLR,
      ST_CNT_RD,
      ST_CNT_CHK,
      ST_CNT_WR,
      ST_PUSH0,
      ST_POP,
      ST_POPCHK,
      ST_BD_RD,
      ST_BD_CHK,
      ST_BD_ACC,
      ST_SEL_INIT,
      ST_SEL_RD,
      ST_SEL_W,
      ST_SEL_CMP,
      ST_SEL_PUSH
   } state_type;

   typedef struct packed {
      logic idle;
      logic tbl_clear;
      logic freq_clear;
      logic cnt_rd;
      logic cnt_chk;
      logic cnt_wr;
      logic push_init;
      logic pop;
      logic pop_chk;
      logic bd_rd;
      logic bd_chk;
      logic bd_acc;
      logic sel_init;
      logic sel_rd;
      logic sel_w;
      logic sel_cmp;
      logic sel_push;
   } cmd_type;

   typedef struct packed {
      logic tbl_sweep_last;
      logic freq_sweep_last;
      logic count_skip;
      logic cnt_last;
      logic sp_zero;
      logic popped_old;
      logic m_zero;
      logic sym_last;
      logic sel_done;
      logic scan_last;
   } stat_type;

endpackage

### rtl/dfr_ram.sv
module dfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/dfr_ctrl.sv
module dfr_ctrl
   import dfr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  op_type   operation,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TCLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_TCLR: begin
            cmd.tbl_clear = 1'b1;
            if (stat.tbl_sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (start && operation == OP_RUN) state_in = ST_FCLR;
            else if (start && operation == OP_CLEAR) state_in = ST_TCLR;
         end
         ST_FCLR: begin
            cmd.freq_clear = 1'b1;
            if (stat.freq_sweep_last) begin
               state_in = stat.count_skip ? ST_PUSH0 : ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = ST_CNT_CHK;
         end
         ST_CNT_CHK: begin
            cmd.cnt_chk = 1'b1;
            state_in    = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = stat.cnt_last ? ST_PUSH0 : ST_CNT_RD;
         end
         ST_PUSH0: begin
            cmd.push_init = 1'b1;
            state_in      = ST_POP;
         end
         ST_POP: begin
            if (stat.sp_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_POPCHK;
            end
         end
         ST_POPCHK: begin
            cmd.pop_chk = 1'b1;
            if (stat.popped_old) state_in = ST_POP;
            else if (stat.m_zero) state_in = ST_SEL_INIT;
            else state_in = ST_BD_RD;
         end
         ST_BD_RD: begin
            cmd.bd_rd = 1'b1;
            state_in  = ST_BD_CHK;
         end
         ST_BD_CHK: begin
            cmd.bd_chk = 1'b1;
            state_in   = ST_BD_ACC;
         end
         ST_BD_ACC: begin
            cmd.bd_acc = 1'b1;
            state_in   = stat.sym_last ? ST_SEL_INIT : ST_BD_RD;
         end
         ST_SEL_INIT: begin
            if (stat.sel_done) begin
               state_in = ST_POP;
            end else begin
               cmd.sel_init = 1'b1;
               state_in     = ST_SEL_RD;
            end
         end
         ST_SEL_RD: begin
            cmd.sel_rd = 1'b1;
            state_in   = ST_SEL_W;
         end
         ST_SEL_W: begin
            cmd.sel_w = 1'b1;
            state_in  = ST_SEL_CMP;
         end
         ST_SEL_CMP: begin
            cmd.sel_cmp = 1'b1;
            state_in    = stat.scan_last ? ST_SEL_PUSH : ST_SEL_RD;
         end
         ST_SEL_PUSH: begin
            cmd.sel_push = 1'b1;
            state_in     = ST_SEL_INIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/dfr_dp.sv
module dfr_dp
   import dfr_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  req_type               req_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  rsp_valid,
   output rsp_type               rsp_item
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int SA_W = $clog2(STACK_DEPTH);

   // configuration
   logic [SCNT_W-1:0]  state_count_ff, state_count_in;
   logic [STATE_W-1:0] initial_ff, initial_in;
   logic [MCNT_W-1:0]  symbol_count_ff, symbol_count_in;

   // walk control
   logic [TBL_AW-1:0]  idx_ff, idx_in;
   logic [STATE_W-1:0] s_ff, s_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [NUM_W-1:0]   next_ff, next_in;
   logic               ovf_ff, ovf_in;
   logic [LIST_W-1:0]  cnt_ff, cnt_in;
   logic [LIST_W-1:0]  i_ff, i_in;
   logic [LIST_W-1:0]  pushed_ff, pushed_in;
   logic               best_ok_ff, best_ok_in;
   logic               hit_ff, hit_in;
   logic               new_ff, new_in;
   logic [MAX_STATES-1:0] map_valid_ff, map_valid_in;
   logic [MAX_STATES-1:0] mark_ff, mark_in;
   logic [MAX_STATES-1:0] done_ff, done_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;

   // payload
   logic [STATE_W-1:0] cur_ff, cur_in;
   logic [STATE_W-1:0] d_ff, d_in;
   logic [FREQ_W-1:0]  f_ff, f_in;
   logic [STATE_W-1:0] best_d_ff, best_d_in;
   logic [WGT_W-1:0]   best_w_ff, best_w_in;

   // memories
   logic               tbl_we;
   logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
   logic [ENTRY_W-1:0] tbl_wdata, tbl_rd;
   logic               freq_we;
   logic [SYM_W-1:0]   freq_waddr;
   logic [FREQ_W-1:0]  freq_wdata, freq_rd;
   logic               map_we;
   logic [STATE_W-1:0] map_rd;
   logic               stk_we;
   logic [SA_W-1:0]    stk_waddr, stk_raddr;
   logic [STATE_W-1:0] stk_wdata, stk_rd;
   logic               wgt_we;
   logic [STATE_W-1:0] wgt_raddr;
   logic [WGT_W-1:0]   wgt_wdata, wgt_rd;
   logic               dl_we;
   logic [STATE_W-1:0] dl_rd;

   logic [SCNT_W-1:0]  n_eff;
   logic [MCNT_W-1:0]  m_eff;
   logic               accept;
   logic               entry_hit;
   logic [STATE_W-1:0] entry_dest;
   logic               push_req;
   logic [STATE_W-1:0] push_val;
   logic               stack_full;
   logic [SP_W-1:0]    sp_dec;
   logic               better;

   assign n_eff = (state_count_ff > SCNT_W'(MAX_STATES)) ? SCNT_W'(MAX_STATES)
                                                          : state_count_ff;
   assign m_eff = (symbol_count_ff > MCNT_W'(MAX_SYMBOLS)) ? MCNT_W'(MAX_SYMBOLS)
                                                            : symbol_count_ff;
   assign accept     = cmd.idle && start;
   assign entry_dest = tbl_rd[STATE_W-1:0];
   assign entry_hit  = tbl_rd[STATE_W] && ({1'b0, entry_dest} < n_eff);
   assign stack_full = (sp_ff == SP_W'(STACK_DEPTH));
   assign sp_dec     = sp_ff - SP_W'(1);
   assign push_req   = (cmd.push_init && ({1'b0, initial_ff} < n_eff)) || cmd.sel_push;
   assign push_val   = cmd.push_init ? initial_ff : best_d_ff;
   assign better     = !best_ok_ff || (wgt_rd < best_w_ff) ||
                       (wgt_rd == best_w_ff && d_ff < best_d_ff);

   always_comb begin
      state_count_in  = state_count_ff;
      initial_in      = initial_ff;
      symbol_count_in = symbol_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STATE_COUNT:   state_count_in  = csr_wdata;
            CSR_INITIAL_STATE: initial_in      = csr_wdata[STATE_W-1:0];
            CSR_SYMBOL_COUNT:  symbol_count_in = csr_wdata[MCNT_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      s_in         = s_ff;
      sym_in       = sym_ff;
      sp_in        = sp_ff;
      next_in      = next_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      pushed_in    = pushed_ff;
      best_ok_in   = best_ok_ff;
      hit_in       = hit_ff;
      new_in       = new_ff;
      map_valid_in = map_valid_ff;
      mark_in      = mark_ff;
      done_in      = done_ff;
      cur_in       = cur_ff;
      d_in         = d_ff;
      f_in         = f_ff;
      best_d_in    = best_d_ff;
      best_w_in    = best_w_ff;
      rsp_valid_in = accept && req_item.operation == OP_READ;
      rsp_hit_in   = map_valid_ff[req_item.src_state];

      if (cmd.idle) idx_in = '0;
      if (cmd.tbl_clear || cmd.freq_clear) idx_in = idx_ff + TBL_AW'(1);

      if (cmd.freq_clear) begin
         map_valid_in = '0;
         next_in      = '0;
         sp_in        = '0;
         ovf_in       = 1'b0;
         s_in         = '0;
         sym_in       = '0;
      end

      if (cmd.cnt_chk) hit_in = entry_hit;

      if (cmd.cnt_wr) begin
         if ({1'b0, sym_ff} == m_eff - MCNT_W'(1)) begin
            sym_in = '0;
            s_in   = s_ff + STATE_W'(1);
         end else begin
            sym_in = sym_ff + SYM_W'(1);
         end
      end

      if (push_req) begin
         if (stack_full) ovf_in = 1'b1;
         else sp_in = sp_ff + SP_W'(1);
      end

      if (cmd.pop) sp_in = sp_dec;

      if (cmd.pop_chk) begin
         cur_in = stk_rd;
         if (!map_valid_ff[stk_rd]) begin
            map_valid_in[stk_rd] = 1'b1;
            next_in   = next_ff + NUM_W'(1);
            mark_in   = '0;
            done_in   = '0;
            cnt_in    = '0;
            pushed_in = '0;
            sym_in    = '0;
         end
      end

      if (cmd.bd_chk) begin
         hit_in = entry_hit;
         d_in   = entry_dest;
         f_in   = freq_rd;
         new_in = !mark_ff[entry_dest];
         if (entry_hit && !mark_ff[entry_dest]) begin
            mark_in[entry_dest] = 1'b1;
            cnt_in = cnt_ff + LIST_W'(1);
         end
      end

      if (cmd.bd_acc) sym_in = sym_ff + SYM_W'(1);

      if (cmd.sel_init) begin
         i_in       = '0;
         best_ok_in = 1'b0;
      end

      if (cmd.sel_w) d_in = dl_rd;

      if (cmd.sel_cmp) begin
         i_in = i_ff + LIST_W'(1);
         if (!done_ff[d_ff] && better) begin
            best_ok_in = 1'b1;
            best_d_in  = d_ff;
            best_w_in  = wgt_rd;
         end
      end

      if (cmd.sel_push) begin
         done_in[best_d_ff] = 1'b1;
         pushed_in = pushed_ff + LIST_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff  <= SCNT_W'(MAX_STATES);
         initial_ff      <= '0;
         symbol_count_ff <= MCNT_W'(MAX_SYMBOLS);
         idx_ff          <= '0;
         s_ff            <= '0;
         sym_ff          <= '0;
         sp_ff           <= '0;
         next_ff         <= '0;
         ovf_ff          <= 1'b0;
         cnt_ff          <= '0;
         i_ff            <= '0;
         pushed_ff       <= '0;
         best_ok_ff      <= 1'b0;
         hit_ff          <= 1'b0;
         new_ff          <= 1'b0;
         map_valid_ff    <= '0;
         mark_ff         <= '0;
         done_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_hit_ff      <= 1'b0;
      end else begin
         state_count_ff  <= state_count_in;
         initial_ff      <= initial_in;
         symbol_count_ff <= symbol_count_in;
         idx_ff          <= idx_in;
         s_ff            <= s_in;
         sym_ff          <= sym_in;
         sp_ff           <= sp_in;
         next_ff         <= next_in;
         ovf_ff          <= ovf_in;
         cnt_ff          <= cnt_in;
         i_ff            <= i_in;
         pushed_ff       <= pushed_in;
         best_ok_ff      <= best_ok_in;
         hit_ff          <= hit_in;
         new_ff          <= new_in;
         map_valid_ff    <= map_valid_in;
         mark_ff         <= mark_in;
         done_ff         <= done_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_hit_ff      <= rsp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      d_ff      <= d_in;
      f_ff      <= f_in;
      best_d_ff <= best_d_in;
      best_w_ff <= best_w_in;
   end

   // transition table: sweep clear or load write, walk reads
   assign tbl_we    = cmd.tbl_clear || (accept && req_item.operation == OP_LOAD);
   assign tbl_waddr = cmd.tbl_clear ? idx_ff : {req_item.src_state, req_item.symbol};
   assign tbl_wdata = (cmd.tbl_clear || !req_item.dest_present) ? '0
                      : {1'b1, req_item.dest_state};
   assign tbl_raddr = cmd.cnt_rd ? {s_ff, sym_ff} : {cur_ff, sym_ff};

   dfr_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rd)
   );

   assign freq_we    = cmd.freq_clear || (cmd.cnt_wr && hit_ff);
   assign freq_waddr = cmd.freq_clear ? idx_ff[SYM_W-1:0] : sym_ff;
   assign freq_wdata = cmd.freq_clear ? '0 : freq_rd + FREQ_W'(1);

   dfr_ram #(.WIDTH(FREQ_W), .DEPTH(MAX_SYMBOLS)) u_freq (
      .clock (clock),
      .we    (freq_we),
      .waddr (freq_waddr),
      .wdata (freq_wdata),
      .raddr (sym_ff),
      .rdata (freq_rd)
   );

   assign map_we = cmd.pop_chk && !map_valid_ff[stk_rd];

   dfr_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (stk_rd),
      .wdata (next_ff[STATE_W-1:0]),
      .raddr (req_item.src_state),
      .rdata (map_rd)
   );

   assign stk_we    = push_req && !stack_full;
   assign stk_waddr = sp_ff[SA_W-1:0];
   assign stk_wdata = push_val;
   assign stk_raddr = sp_dec[SA_W-1:0];

   dfr_ram #(.WIDTH(STATE_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rd)
   );

   // a destination seen for the first time starts from zero weight
   assign wgt_we    = cmd.bd_acc && hit_ff;
   assign wgt_wdata = (new_ff ? '0 : wgt_rd) + WGT_W'(f_ff);
   assign wgt_raddr = cmd.bd_chk ? entry_dest : dl_rd;

   dfr_ram #(.WIDTH(WGT_W), .DEPTH(MAX_STATES)) u_wgt (
      .clock (clock),
      .we    (wgt_we),
      .waddr (d_ff),
      .wdata (wgt_wdata),
      .raddr (wgt_raddr),
      .rdata (wgt_rd)
   );

   assign dl_we = cmd.bd_chk && entry_hit && !mark_ff[entry_dest];

   dfr_ram #(.WIDTH(STATE_W), .DEPTH(MAX_SYMBOLS)) u_dlist (
      .clock (clock),
      .we    (dl_we),
      .waddr (cnt_ff[SYM_W-1:0]),
      .wdata (entry_dest),
      .raddr (i_ff[SYM_W-1:0]),
      .rdata (dl_rd)
   );

   always_comb begin
      stat.tbl_sweep_last  = (idx_ff == TBL_AW'(TBL_DEPTH - 1));
      stat.freq_sweep_last = (idx_ff[SYM_W-1:0] == SYM_W'(MAX_SYMBOLS - 1));
      stat.count_skip      = (n_eff == '0) || (m_eff == '0);
      stat.cnt_last        = ({1'b0, s_ff} == n_eff - SCNT_W'(1)) &&
                             ({1'b0, sym_ff} == m_eff - MCNT_W'(1));
      stat.sp_zero         = (sp_ff == '0);
      stat.popped_old      = map_valid_ff[stk_rd];
      stat.m_zero          = (m_eff == '0);
      stat.sym_last        = ({1'b0, sym_ff} == m_eff - MCNT_W'(1));
      stat.sel_done        = (pushed_ff == cnt_ff);
      stat.scan_last       = (i_ff == cnt_ff - LIST_W'(1));
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_item.new_number      = rsp_hit_ff ? map_rd : '0;
   assign rsp_item.is_numbered     = rsp_hit_ff;
   assign rsp_item.numbered_total  = next_ff;
   assign rsp_item.stack_overflow  = ovf_ff;

endmodule

### rtl/dfa_depth_first_state_renumber_top.sv
// Depth-first DFA state renumbering. Pulse start with req_item while busy is low to
// issue a transaction. Loads and reads leave busy low and may follow back to back; a
// read answers with rsp_valid for exactly one cycle, in the cycle after it is taken,
// and the receiver cannot stall it. Clear, and the clearing pass that follows reset,
// sweep the 16384-entry transition memory one entry a cycle with busy high. A run
// holds busy while it clears the symbol frequencies, counts symbol use over the n*m
// table entries, then pops states; for each newly numbered state it collects the
// destinations of its symbols, weighs them and orders the distinct ones, where
// n and m are the states and symbols in use; all steps are set by the single read port
// of each memory. Configuration writes land at once and must only be made while idle.
module dfa_depth_first_state_renumber_top
   import dfr_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   output logic                  rsp_valid,
   output rsp_type               rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   dfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_item.operation),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd)
   );

   dfr_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/dfr_chk.sv
module dfr_chk
   import dfr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // a result only follows a read transaction
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_item.operation == OP_READ))
      else $error("result without a read transaction");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   a_unnumbered_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.is_numbered |-> rsp_item.new_number == '0)
      else $error("unnumbered state reports a number");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.operation == OP_RUN |=> busy)
      else $error("run did not raise busy");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> busy)
      else $error("no clearing pass after reset");

endmodule

bind dfa_depth_first_state_renumber_top dfr_chk u_dfr_chk (.*);

### test/dfa_depth_first_state_renumber_top_test.sv
module dfa_depth_first_state_renumber_top_test;
   import dfr_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int WALK_DEPTH  = STACK_DEPTH_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_item;
   logic                  rsp_valid;
   rsp_type               rsp_item;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dfa_depth_first_state_renumber_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the block
   logic [8:0] trans_shadow [TBL_DEPTH];
   int         sym_freq [MAX_SYMBOLS];
   bit         num_valid [MAX_STATES];
   int         num_value [MAX_STATES];
   logic [7:0] walk_stk [WALK_DEPTH];
   int         walk_sp;
   int         next_num;
   bit         walk_ovf;
   logic [8:0] cfg_states;
   logic [7:0] cfg_init;
   logic [6:0] cfg_symbols;

   rsp_type mapping_q [$];
   int      fail_count;
   int      items_sent;
   int      idle_pct;
   int      cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (mapping_q.size() == 0) begin
            $display("%0t: unexpected transaction, actual %p", $time, rsp_item);
            fail_count++;
         end else begin
            exp_r = mapping_q.pop_front();
            if (rsp_item.new_number !== exp_r.new_number) begin
               $display("%0t: new_number expected %0d actual %0d", $time,
                        exp_r.new_number, rsp_item.new_number);
               fail_count++;
            end
            if (rsp_item.is_numbered !== exp_r.is_numbered) begin
               $display("%0t: is_numbered expected %0d actual %0d", $time,
                        exp_r.is_numbered, rsp_item.is_numbered);
               fail_count++;
            end
            if (rsp_item.numbered_total !== exp_r.numbered_total) begin
               $display("%0t: numbered_total expected %0d actual %0d", $time,
                        exp_r.numbered_total, rsp_item.numbered_total);
               fail_count++;
            end
            if (rsp_item.stack_overflow !== exp_r.stack_overflow) begin
               $display("%0t: stack_overflow expected %0d actual %0d", $time,
                        exp_r.stack_overflow, rsp_item.stack_overflow);
               fail_count++;
            end
         end
      end
   end

   function automatic int used_states();
      return (cfg_states > MAX_STATES) ? MAX_STATES : int'(cfg_states);
   endfunction

   function automatic int used_symbols();
      return (cfg_symbols > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(cfg_symbols);
   endfunction

   function automatic bit edge_dest(int s, int sym, int n, output int d);
      logic [8:0] e;
      e = trans_shadow[s * MAX_SYMBOLS + sym];
      d = e[7:0];
      return e[8] && (d < n);
   endfunction

   function automatic void stack_push(int s);
      if (walk_sp >= WALK_DEPTH) walk_ovf = 1'b1;
      else begin
         walk_stk[walk_sp] = s[7:0];
         walk_sp++;
      end
   endfunction

   function automatic void renumber_walk();
      int n, m, s, sym, d, i, j, cnt, kd, kw;
      int dl [MAX_SYMBOLS];
      int dw [MAX_SYMBOLS];
      n = used_states();
      m = used_symbols();
      for (i = 0; i < MAX_SYMBOLS; i++) sym_freq[i] = 0;
      for (s = 0; s < n; s++)
         for (sym = 0; sym < m; sym++)
            if (edge_dest(s, sym, n, d)) sym_freq[sym]++;
      for (i = 0; i < MAX_STATES; i++) begin
         num_valid[i] = 1'b0;
         num_value[i] = 0;
      end
      next_num = 0;
      walk_sp = 0;
      walk_ovf = 1'b0;
      if (cfg_init < n) stack_push(cfg_init);
      while (walk_sp > 0) begin
         walk_sp--;
         s = walk_stk[walk_sp];
         if (num_valid[s]) continue;
         num_valid[s] = 1'b1;
         num_value[s] = next_num;
         next_num++;
         cnt = 0;
         for (sym = 0; sym < m; sym++) begin
            if (!edge_dest(s, sym, n, d)) continue;
            for (i = 0; i < cnt; i++)
               if (dl[i] == d) break;
            if (i == cnt) begin
               dl[cnt] = d;
               dw[cnt] = 0;
               cnt++;
            end
            dw[i] += sym_freq[sym];
         end
         // order by weight, then by destination
         for (i = 1; i < cnt; i++) begin
            kd = dl[i];
            kw = dw[i];
            j = i;
            while (j > 0 && (dw[j-1] > kw || (dw[j-1] == kw && dl[j-1] > kd))) begin
               dl[j] = dl[j-1];
               dw[j] = dw[j-1];
               j--;
            end
            dl[j] = kd;
            dw[j] = kw;
         end
         for (i = 0; i < cnt; i++) stack_push(dl[i]);
      end
   endfunction

   function automatic void predict_item(req_type r);
      rsp_type x;
      int src;
      src = r.src_state;
      case (r.operation)
         OP_LOAD: trans_shadow[src * MAX_SYMBOLS + r.symbol] =
                     r.dest_present ? {1'b1, r.dest_state} : 9'd0;
         OP_RUN: renumber_walk();
         OP_CLEAR: for (int i = 0; i < TBL_DEPTH; i++) trans_shadow[i] = 9'd0;
         default: begin
            x.is_numbered    = num_valid[src];
            x.new_number     = num_valid[src] ? num_value[src][7:0] : 8'd0;
            x.numbered_total = next_num[8:0];
            x.stack_overflow = walk_ovf;
            mapping_q = {mapping_q, x};
         end
      endcase
   endfunction

   task automatic idle_cycles(int k);
      repeat (k) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic send_item(req_type r);
      while ($urandom_range(99) < idle_pct) idle_cycles(1);
      @(negedge clock);
      start = 1'b1;
      req_item = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_item(r);
      items_sent++;
   endtask

   task automatic send_op(op_type op, int src, int sym, int dst, bit pres);
      req_type r;
      r.operation    = op;
      r.src_state    = src[7:0];
      r.symbol       = sym[5:0];
      r.dest_state   = dst[7:0];
      r.dest_present = pres;
      send_item(r);
   endtask

   // hold until the block is idle and every read has answered
   task automatic drain();
      idle_cycles(1);
      @(posedge clock);
      while (busy || mapping_q.size() != 0) @(posedge clock);
      idle_cycles(4);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      drain();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val[CSR_DATA_W-1:0];
      case (idx)
         CSR_STATE_COUNT:   cfg_states  = val[8:0];
         CSR_INITIAL_STATE: cfg_init    = val[7:0];
         CSR_SYMBOL_COUNT:  cfg_symbols = val[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(int sc, int init, int mc);
      csr_write(CSR_STATE_COUNT, sc);
      csr_write(CSR_INITIAL_STATE, init);
      csr_write(CSR_SYMBOL_COUNT, mc);
   endtask

   task automatic test_small_graph();
      // read before any run, then a graph with tied weights
      send_op(OP_READ, 0, 0, 0, 1'b0);
      configure(4, 0, 2);
      send_op(OP_LOAD, 0, 0, 1, 1'b1);
      send_op(OP_LOAD, 0, 1, 2, 1'b1);
      send_op(OP_LOAD, 1, 0, 3, 1'b1);
      send_op(OP_LOAD, 2, 1, 200, 1'b1);
      send_op(OP_LOAD, 3, 1, 0, 1'b1);
      send_op(OP_LOAD, 3, 0, 2, 1'b0);
      send_op(OP_RUN, 0, 0, 0, 1'b0);
      for (int s = 0; s < 4; s++) send_op(OP_READ, s, 0, 0, 1'b0);
      send_op(OP_READ, 255, 63, 255, 1'b1);
      // walk from a state beyond the range numbers nothing
      csr_write(CSR_INITIAL_STATE, 9);
      send_op(OP_RUN, 0, 0, 0, 1'b0);
      send_op(OP_READ, 0, 0, 0, 1'b0);
   endtask

   task automatic test_extreme_config();
      send_op(OP_CLEAR, 0, 0, 0, 1'b0);
      configure(256, 255, 64);
      send_op(OP_LOAD, 255, 63, 0, 1'b1);
      send_op(OP_LOAD, 0, 0, 255, 1'b1);
      send_op(OP_LOAD, 0, 63, 128, 1'b1);
      send_op(OP_LOAD, 128, 32, 255, 1'b1);
      send_op(OP_RUN, 0, 0, 0, 1'b0);
      send_op(OP_READ, 0, 0, 0, 1'b0);
      send_op(OP_READ, 255, 0, 0, 1'b0);
      send_op(OP_READ, 128, 0, 0, 1'b0);
      // oversized registers saturate
      configure(511, 0, 127);
      send_op(OP_RUN, 0, 0, 0, 1'b0);
      send_op(OP_READ, 255, 0, 0, 1'b0);
      configure(0, 0, 0);
      send_op(OP_RUN, 0, 0, 0, 1'b0);
      send_op(OP_READ, 0, 0, 0, 1'b0);
      configure(2, 1, 1);
      send_op(OP_RUN, 0, 0, 0, 1'b0);
      send_op(OP_READ, 1, 0, 0, 1'b0);
      // a write to an unused index lands nowhere
      csr_write(CSR_UNUSED, 9'h1ff);
      send_op(OP_CLEAR, 0, 0, 0, 1'b0);
      send_op(OP_RUN, 0, 0, 0, 1'b0);
      send_op(OP_READ, 1, 0, 0, 1'b0);
   endtask

   task automatic random_noise();
      req_type     r;
      logic [31:0] raw;
      raw = $urandom();
      r = raw[$bits(req_type)-1:0];
      if (r.operation == OP_CLEAR && $urandom_range(30) != 0) r.operation = OP_READ;
      send_item(r);
   endtask

   task automatic test_random_episodes(int pct, int item_goal);
      int sc, mc, init, loads;
      idle_pct = pct;
      while (items_sent < item_goal) begin
         sc = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 2);
         mc = $urandom_range(8, 1);
         init = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(sc - 1);
         configure(sc, init, mc);
         if ($urandom_range(20) == 0) send_op(OP_CLEAR, 0, 0, 0, 1'b0);
         loads = $urandom_range(3 * sc, 4);
         repeat (loads) begin
            if ($urandom_range(9) == 0) random_noise();
            else send_op(OP_LOAD, $urandom_range(sc - 1), $urandom_range(mc - 1),
                         ($urandom_range(15) == 0) ? $urandom_range(255)
                                                   : $urandom_range(sc - 1),
                         $urandom_range(7) != 0);
         end
         send_op(OP_RUN, 0, 0, 0, 1'b0);
         for (int s = 0; s < sc; s++) send_op(OP_READ, s, 0, 0, 1'b0);
         repeat ($urandom_range(3)) random_noise();
         if ($urandom_range(5) == 0) drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fail_count = 0;
      items_sent = 0;
      idle_pct = 0;
      cycle_count = 0;
      cfg_states = 9'd256;
      cfg_init = 8'd0;
      cfg_symbols = 7'd64;
      next_num = 0;
      walk_sp = 0;
      walk_ovf = 1'b0;
      for (int i = 0; i < TBL_DEPTH; i++) trans_shadow[i] = 9'd0;
      for (int i = 0; i < MAX_STATES; i++) begin
         num_valid[i] = 1'b0;
         num_value[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_small_graph();
      test_extreme_config();
      test_random_episodes(0, 350);
      test_random_episodes(65, 700);
      drain();
      test_random_episodes(6, 1000);
      test_random_episodes(0, 1300);

      drain();
      idle_cycles(20);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
